// File: hdl/sfmt_random_word_generator_assert.svh
// Assertion macros shared by the generator's checker.
`ifndef SFMT_RANDOM_WORD_GENERATOR_ASSERT_SVH
`define SFMT_RANDOM_WORD_GENERATOR_ASSERT_SVH

// Clocked check, off while reset is high.
`define SRWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SRWG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/srwg_pkg.sv
// Shared types, constants and the mix function of the random word generator.
package srwg_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 156;
  localparam int unsigned LAG_OFFSET_DEF   = 122;
  localparam int unsigned WARMUP_STEPS_DEF = 1000;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ENTRY_W = 128;

  localparam logic [WORD_W-1:0] SEED_RESET = 32'h1234_5678;
  localparam logic [WORD_W-1:0] LCG_MUL    = 32'hdead_beef;
  localparam logic [WORD_W-1:0] LCG_ADD    = 32'habcd_ef1c;

  localparam logic [ENTRY_W-1:0] MIX_MASK =
    128'hDDFECB7F_DFFFFFEF_BFFFFFF6_BFFAFFFF;

  localparam int unsigned SHIFT_BYTE  = 8;
  localparam int unsigned SHIFT_RWORD = 11;
  localparam int unsigned SHIFT_LWORD = 18;

  typedef enum logic {
    OP_REPEAT,
    OP_DRAW
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

  // One SFMT-style recursion on 128-bit entries.
  function automatic logic [ENTRY_W-1:0] mix_entry(
    input logic [ENTRY_W-1:0] a,
    input logic [ENTRY_W-1:0] b,
    input logic [ENTRY_W-1:0] c,
    input logic [ENTRY_W-1:0] d
  );
    logic [ENTRY_W-1:0] b_sh;
    logic [ENTRY_W-1:0] d_sh;
    b_sh = '0;
    d_sh = '0;
    for (int k = 0; k < 4; k++) begin
      b_sh[k*WORD_W +: WORD_W] = b[k*WORD_W +: WORD_W] >> SHIFT_RWORD;
      d_sh[k*WORD_W +: WORD_W] = d[k*WORD_W +: WORD_W] << SHIFT_LWORD;
    end
    return a ^ (a << SHIFT_BYTE) ^ (b_sh & MIX_MASK) ^ (c >> SHIFT_BYTE) ^ d_sh;
  endfunction

endpackage

// File: hdl/srwg_front.sv
// Front end: takes requests, classifies them and queues them for the back end.
module srwg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  draw_request,
  output logic                  busy,
  input  logic                  pop,
  output srwg_pkg::queue_head_t head
);

  srwg_pkg::op_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  srwg_pkg::op_t op_in;

  assign busy  = (count == 2'd2);
  assign push  = start && !busy;
  assign op_in = draw_request ? srwg_pkg::OP_DRAW : srwg_pkg::OP_REPEAT;

  assign head.valid = (count != 2'd0);
  assign head.op    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/srwg_back.sv
// Back end: seeds the pool, runs the mix steps and reads words out.
module srwg_back #(
  parameter int unsigned POOL_ENTRIES = srwg_pkg::POOL_ENTRIES_DEF,
  parameter int unsigned LAG_OFFSET   = srwg_pkg::LAG_OFFSET_DEF,
  parameter int unsigned WARMUP_STEPS = srwg_pkg::WARMUP_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srwg_pkg::queue_head_t head,
  output logic                  pop,
  input  logic                  seed_we,
  input  logic [31:0]           seed_value,
  output logic                  done,
  output logic [31:0]           random_word
);

  localparam int unsigned PTR_W      = $clog2(POOL_ENTRIES);
  localparam int unsigned POOL_WORDS = 4 * POOL_ENTRIES;
  localparam int unsigned POS_W      = $clog2(POOL_WORDS + 1);
  localparam int unsigned FILL_W     = $clog2(POOL_WORDS);
  localparam int unsigned STEP_MAX   =
    (WARMUP_STEPS > POOL_ENTRIES) ? WARMUP_STEPS : POOL_ENTRIES;
  localparam int unsigned STEP_W     = $clog2(STEP_MAX + 1);
  localparam int unsigned LAG_MOD    = LAG_OFFSET % POOL_ENTRIES;

  localparam logic [PTR_W:0]    N_EXT      = (PTR_W + 1)'(POOL_ENTRIES);
  localparam logic [PTR_W:0]    LAG_EXT    = (PTR_W + 1)'(LAG_MOD);
  localparam logic [PTR_W-1:0]  LAST_ENTRY = PTR_W'(POOL_ENTRIES - 1);
  localparam logic [PTR_W-1:0]  BACK_TWO   = PTR_W'(POOL_ENTRIES - 2);
  localparam logic [POS_W-1:0]  WORDS_END  = POS_W'(POOL_WORDS);
  localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(POOL_WORDS - 1);
  localparam logic [STEP_W-1:0] WARM_CNT   = STEP_W'(WARMUP_STEPS);
  localparam logic [STEP_W-1:0] REFILL_CNT = STEP_W'(POOL_ENTRIES);
  localparam logic [STEP_W-1:0] STEP_ONE   = STEP_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX_AB,
    ST_MIX_CD,
    ST_MIX_WR,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t        state;
  logic [31:0]   seed;
  logic [31:0]   fill_value;
  logic [95:0]   fill_buf;
  logic [FILL_W-1:0] fill_cnt;
  logic [PTR_W-1:0]  mix_ptr;
  logic [STEP_W-1:0] step_left;
  logic [POS_W-1:0]  out_pos;
  logic          seeded;
  logic [31:0]   last_word;
  logic [127:0]  a_q;
  logic [127:0]  b_q;

  logic [127:0]  pool [POOL_ENTRIES];
  logic [127:0]  rdata_a;
  logic [127:0]  rdata_b;
  logic [PTR_W-1:0] rd_addr_a;
  logic [PTR_W-1:0] rd_addr_b;
  logic          wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [127:0]  wr_data;

  logic [31:0]      lcg_next;
  logic [PTR_W:0]   lag_sum;
  logic [PTR_W-1:0] ptr_lag;
  logic [PTR_W-1:0] ptr_m1;
  logic [PTR_W-1:0] ptr_m2;
  logic [PTR_W-1:0] ptr_next;
  logic [PTR_W-1:0] out_entry;
  logic [31:0]      word_sel;

  assign lcg_next = fill_value * srwg_pkg::LCG_MUL + srwg_pkg::LCG_ADD;

  assign lag_sum  = {1'b0, mix_ptr} + LAG_EXT;
  assign ptr_lag  = (lag_sum >= N_EXT) ? PTR_W'(lag_sum - N_EXT) : PTR_W'(lag_sum);
  assign ptr_m1   = (mix_ptr == '0) ? LAST_ENTRY : mix_ptr - PTR_W'(1);
  assign ptr_m2   = (mix_ptr >= PTR_W'(2)) ? mix_ptr - PTR_W'(2) : mix_ptr + BACK_TWO;
  assign ptr_next = (mix_ptr == LAST_ENTRY) ? '0 : mix_ptr + PTR_W'(1);

  assign out_entry = out_pos[PTR_W+1:2];
  assign word_sel  = rdata_a[{out_pos[1:0], 5'b0} +: 32];

  assign pop = (state == ST_IDLE) && head.valid;

  always_comb begin
    unique case (state)
      ST_MIX_AB: begin
        rd_addr_a = mix_ptr;
        rd_addr_b = ptr_lag;
      end
      ST_MIX_CD: begin
        rd_addr_a = ptr_m2;
        rd_addr_b = ptr_m1;
      end
      default: begin
        rd_addr_a = out_entry;
        rd_addr_b = ptr_m1;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = mix_ptr;
    wr_data = srwg_pkg::mix_entry(a_q, b_q, rdata_a, rdata_b);
    if (state == ST_FILL && fill_cnt[1:0] == 2'd3) begin
      wr_en   = 1'b1;
      wr_addr = fill_cnt[FILL_W-1:2];
      wr_data = {lcg_next, fill_buf};
    end else if (state == ST_MIX_WR) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pool[wr_addr] <= wr_data;
    end
    rdata_a <= pool[rd_addr_a];
    rdata_b <= pool[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (state == ST_FILL) begin
      fill_buf <= {lcg_next, fill_buf[95:32]};
    end
    if (state == ST_MIX_CD) begin
      a_q <= rdata_a;
      b_q <= rdata_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      seed        <= srwg_pkg::SEED_RESET;
      fill_value  <= '0;
      fill_cnt    <= '0;
      mix_ptr     <= '0;
      step_left   <= '0;
      out_pos     <= '0;
      seeded      <= 1'b0;
      last_word   <= '0;
      done        <= 1'b0;
      random_word <= '0;
    end else begin
      done <= 1'b0;
      if (seed_we) begin
        seed <= seed_value;
      end
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            if (head.op == srwg_pkg::OP_REPEAT) begin
              done        <= 1'b1;
              random_word <= last_word;
            end else if (!seeded) begin
              state      <= ST_FILL;
              fill_value <= seed;
              fill_cnt   <= '0;
            end else if (out_pos == WORDS_END) begin
              state     <= ST_MIX_AB;
              step_left <= REFILL_CNT;
              out_pos   <= '0;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_FILL: begin
          fill_value <= lcg_next;
          fill_cnt   <= fill_cnt + FILL_W'(1);
          if (fill_cnt == FILL_LAST) begin
            seeded    <= 1'b1;
            out_pos   <= '0;
            mix_ptr   <= '0;
            step_left <= WARM_CNT;
            state     <= (WARM_CNT == '0) ? ST_READ : ST_MIX_AB;
          end
        end
        ST_MIX_AB: begin
          state <= ST_MIX_CD;
        end
        ST_MIX_CD: begin
          state <= ST_MIX_WR;
        end
        ST_MIX_WR: begin
          mix_ptr   <= ptr_next;
          step_left <= step_left - STEP_ONE;
          state     <= (step_left == STEP_ONE) ? ST_READ : ST_MIX_AB;
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          done        <= 1'b1;
          random_word <= word_sel;
          last_word   <= word_sel;
          out_pos     <= out_pos + POS_W'(1);
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/sfmt_random_word_generator.sv
// Top level of the SFMT-style random word generator.
//
//   Channel   Transfer handshake           Payload
//   request   start high, busy low         draw_request
//   config    seed_valid and seed_ready    seed_value
//   result    done, one-cycle strobe       random_word
//
// A draw from a filled pool passes through a queue pop and a registered pool read.
// A request without draw_request is answered with the last word.
// First draw: 4*POOL_ENTRIES fill words (one LCG multiply each), then the warmup steps.
// Every 4*POOL_ENTRIES words a refill runs POOL_ENTRIES mix steps, each through MIX_AB,
// MIX_CD and MIX_WR, as the two pool read ports fetch its four entries in pairs.
// A 2-deep queue holds requests; busy is high while it is full. No clearing pass
// after reset. Results cannot be stalled.
module sfmt_random_word_generator #(
  parameter int unsigned POOL_ENTRIES = srwg_pkg::POOL_ENTRIES_DEF,
  parameter int unsigned LAG_OFFSET   = srwg_pkg::LAG_OFFSET_DEF,
  parameter int unsigned WARMUP_STEPS = srwg_pkg::WARMUP_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        draw_request,
  input  logic        seed_valid,
  output logic        seed_ready,
  input  logic [31:0] seed_value,
  output logic        done,
  output logic [31:0] random_word
);

  srwg_pkg::queue_head_t head;
  logic                  pop;

  assign seed_ready = 1'b1;

  srwg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .draw_request (draw_request),
    .busy         (busy),
    .pop          (pop),
    .head         (head)
  );

  srwg_back #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .LAG_OFFSET   (LAG_OFFSET),
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .seed_we     (seed_valid && seed_ready),
    .seed_value  (seed_value),
    .done        (done),
    .random_word (random_word)
  );

endmodule

// File: hdl/srwg_checker.sv
// Port-level checker for the random word generator, bound to the top level.
`include "sfmt_random_word_generator_assert.svh"

module srwg_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] random_word
);

  `SRWG_ASSERT_RST(a_reset_quiet, rst |=> !done && !busy, "done or busy set after reset")
  `SRWG_ASSERT(a_word_holds, !done |-> $stable(random_word), "random_word moved without done")
  `SRWG_ASSERT(a_busy_cause, $rose(busy) |-> $past(start), "busy rose without a transfer")

endmodule

bind sfmt_random_word_generator srwg_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .random_word (random_word)
);
